/* hdl/hrm_pkg.sv */
`default_nettype none

package hrm_pkg;

  // field widths
  localparam int DATA_W    = 16;
  localparam int TGT_W     = 4;
  localparam int CFG_IDX_W = 4;

  // default number of monitored targets
  localparam int NUM_TARGETS_DEF = 5;

  // register reset values
  localparam logic [DATA_W-1:0] POLL_RESET    = 16'd5000;
  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [DATA_W-1:0] CNT_MAX       = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT  = 4'd1;

  // input beat kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_RESP = 1'b1;

  // output beat kinds
  localparam logic KIND_PROBE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

endpackage

`default_nettype wire

/* hdl/hrm_ram.sv */
`default_nettype none

module hrm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 5,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/heartbeat_round_monitor.sv */
`default_nettype none

// Round-based liveness monitor over NUM_TARGETS targets.
// Input channel (in_valid/in_ready): each beat is a one-millisecond tick
// (mode 0) or a response from target "responder" (mode 1).
// Output channel (out_valid/out_ready): probe requests (kind 0) at round
// start and report entries (kind 1) at round end, in target order 0..N-1,
// with last set on the final beat of each burst.
// Config channel (cfg_valid/cfg_ready): index 0 poll interval, index 1
// response timeout, in milliseconds; always ready, write only while idle.
// Per-target state (pending flag and latency) lives in a small RAM.
// Sequence: a response in a round is a RAM read, then a write-back if the
// target was still pending; a probe burst makes one RAM write per target;
// a report makes one RAM read per entry.
// Input is not taken while a burst is in progress.
// The output register holds a beat until taken; a stalled receiver stalls
// the burst, and the block accepts new input once the last beat of a burst
// sits in the output register.
// Reset: registers back to defaults, no round active, no output pending;
// RAM contents are ignored until the first round start rewrites them.
module heartbeat_round_monitor
  import hrm_pkg::*;
#(
  parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input beats
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 mode,
  input  wire logic [TGT_W-1:0]     responder,
  // output beats
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      kind,
  output logic      [TGT_W-1:0]     target,
  output logic                      alive,
  output logic      [DATA_W-1:0]    latency,
  output logic                      last,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam int AW    = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int CW    = $clog2(NUM_TARGETS + 1);
  localparam int WORDW = DATA_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TARGETS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_PROBE,
    S_REP_RD,
    S_REP_WR
  } state_t;

  state_t            state;
  logic [DATA_W-1:0] poll_interval;
  logic [DATA_W-1:0] resp_timeout;
  logic              round_active;
  logic              polled_once;
  logic [DATA_W-1:0] round_elapsed;
  logic [DATA_W-1:0] since_poll;
  logic [CW-1:0]     pending_count;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     resp_addr;

  logic              in_fire;
  logic              can_load;
  logic              load_beat;
  logic              resp_in_range;
  logic [DATA_W-1:0] elapsed_next;
  logic [DATA_W-1:0] since_next;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORDW-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [WORDW-1:0]  ram_rd_data;
  logic              rd_pending;
  logic [DATA_W-1:0] rd_latency;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign can_load  = !out_valid || out_ready;
  assign load_beat = ((state == S_PROBE) || (state == S_REP_WR)) && can_load;

  assign resp_in_range = ({1'b0, responder} < (TGT_W + 1)'(NUM_TARGETS));

  // saturating millisecond counters
  assign elapsed_next = (round_elapsed == CNT_MAX) ? round_elapsed : round_elapsed + 1'b1;
  assign since_next   = (since_poll == CNT_MAX) ? since_poll : since_poll + 1'b1;

  // per-target word: pending flag over latency
  assign rd_pending = ram_rd_data[DATA_W];
  assign rd_latency = ram_rd_data[DATA_W-1:0];

  // ram port control
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = responder[AW-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = {1'b1, {DATA_W{1'b0}}};
    unique case (state)
      S_IDLE: begin
        ram_rd_en = in_fire && (mode == MODE_RESP) && resp_in_range && round_active;
      end
      S_RESP: begin
        ram_wr_en   = rd_pending;
        ram_wr_addr = resp_addr;
        ram_wr_data = {1'b0, round_elapsed};
      end
      S_PROBE: begin
        ram_wr_en = can_load;
      end
      S_REP_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx;
      end
      S_REP_WR: begin
        ram_rd_en = 1'b0;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  hrm_ram #(
    .WIDTH (WORDW),
    .DEPTH (NUM_TARGETS)
  ) u_target_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      poll_interval <= POLL_RESET;
      resp_timeout  <= TIMEOUT_RESET;
      round_active  <= 1'b0;
      polled_once   <= 1'b0;
      round_elapsed <= '0;
      since_poll    <= '0;
      pending_count <= '0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      // configuration writes, unknown indexes dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POLL_INTERVAL) begin
          poll_interval <= cfg_data;
        end else if (cfg_index == REG_RESP_TIMEOUT) begin
          resp_timeout <= cfg_data;
        end
      end

      // output valid: set on a new beat, cleared once taken
      if (load_beat) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (mode == MODE_TICK) begin
              if (!round_active && (!polled_once || since_next >= poll_interval)) begin
                // round start: counters cleared, probes follow
                polled_once   <= 1'b1;
                since_poll    <= '0;
                round_elapsed <= '0;
                round_active  <= 1'b1;
                pending_count <= CW'(NUM_TARGETS);
                idx           <= '0;
                state         <= S_PROBE;
              end else begin
                round_elapsed <= elapsed_next;
                since_poll    <= since_next;
                if (round_active && (elapsed_next >= resp_timeout)) begin
                  round_active  <= 1'b0;
                  pending_count <= '0;
                  idx           <= '0;
                  state         <= S_REP_RD;
                end
              end
            end else if (resp_in_range && round_active) begin
              resp_addr <= responder[AW-1:0];
              state     <= S_RESP;
            end
          end
        end

        S_RESP: begin
          if (rd_pending) begin
            pending_count <= pending_count - 1'b1;
          end
          if (rd_pending && (pending_count == CW'(1))) begin
            round_active <= 1'b0;
            idx          <= '0;
            state        <= S_REP_RD;
          end else begin
            state <= S_IDLE;
          end
        end

        S_PROBE: begin
          if (can_load) begin
            kind    <= KIND_PROBE;
            target  <= TGT_W'(idx);
            alive   <= 1'b0;
            latency <= '0;
            last    <= (idx == LAST_IDX);
            if (idx == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        S_REP_RD: begin
          state <= S_REP_WR;
        end

        S_REP_WR: begin
          if (can_load) begin
            kind    <= KIND_REPORT;
            target  <= TGT_W'(idx);
            alive   <= !rd_pending;
            latency <= rd_pending ? '0 : rd_latency;
            last    <= (idx == LAST_IDX);
            if (idx == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_REP_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sv/heartbeat_round_monitor_test.sv */
module heartbeat_round_monitor_test;
  import hrm_pkg::*;

  localparam int N           = NUM_TARGETS_DEF;
  localparam int SETTLE      = 2 * N + 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int LIMIT       = 2000000;

  // register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic              kind;
    logic [TGT_W-1:0]  target;
    logic              alive;
    logic [DATA_W-1:0] latency;
    logic              last;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 mode = MODE_TICK;
  logic [TGT_W-1:0]     responder = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 kind;
  logic [TGT_W-1:0]     target;
  logic                 alive;
  logic [DATA_W-1:0]    latency;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // expected beats on the output side, oldest first
  beat_t want_q[$];

  // mirror of the monitor's settings and round state
  logic [DATA_W-1:0] poll_ms    = POLL_RESET;
  logic [DATA_W-1:0] timeout_ms = TIMEOUT_RESET;
  logic              round_on   = 1'b0;
  logic              polled     = 1'b0;
  logic [DATA_W-1:0] round_ms   = '0;
  logic [DATA_W-1:0] since_ms   = '0;
  int                pend_cnt   = 0;
  logic              pend[N]    = '{default: 1'b0};
  logic              up[N]      = '{default: 1'b0};
  logic [DATA_W-1:0] lat[N]     = '{default: '0};

  int send_idle   = 0;
  int recv_idle   = 0;
  int stall_left  = 0;
  int errors      = 0;
  int cycles      = 0;

  heartbeat_round_monitor i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .responder  (responder),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .target     (target),
    .alive      (alive),
    .latency    (latency),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // compare every output beat with the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected beat: kind %0d target %0d", kind, target);
        errors++;
      end else begin
        want = want_q.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          errors++;
        end
        if (target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, target);
          errors++;
        end
        if (alive !== want.alive) begin
          $error("alive: expected %0d, got %0d", want.alive, alive);
          errors++;
        end
        if (latency !== want.latency) begin
          $error("latency: expected %0d, got %0d", want.latency, latency);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  // one report entry per target, dead targets at latency zero
  function automatic void queue_report();
    beat_t b;
    for (int i = 0; i < N; i++) begin
      b.kind    = KIND_REPORT;
      b.target  = TGT_W'(i);
      b.alive   = up[i];
      b.latency = up[i] ? lat[i] : '0;
      b.last    = (i == N - 1);
      want_q    = {want_q, b};
    end
  endfunction

  // advance the round state by one accepted input beat
  function automatic void predict_beat(input logic m, input logic [TGT_W-1:0] who);
    beat_t b;
    if (m == MODE_TICK) begin
      if (round_ms != CNT_MAX) round_ms++;
      if (since_ms != CNT_MAX) since_ms++;
      if (round_on) begin
        if (round_ms >= timeout_ms) begin
          for (int i = 0; i < N; i++) begin
            if (pend[i]) begin
              pend[i] = 1'b0;
              up[i]   = 1'b0;
              lat[i]  = '0;
            end
          end
          round_on = 1'b0;
          pend_cnt = 0;
          queue_report();
        end
      end else if (!polled || since_ms >= poll_ms) begin
        // round start: everyone pending, one probe each
        polled   = 1'b1;
        since_ms = '0;
        round_on = 1'b1;
        round_ms = '0;
        pend_cnt = N;
        for (int i = 0; i < N; i++) begin
          pend[i]   = 1'b1;
          up[i]     = 1'b0;
          lat[i]    = '0;
          b.kind    = KIND_PROBE;
          b.target  = TGT_W'(i);
          b.alive   = 1'b0;
          b.latency = '0;
          b.last    = (i == N - 1);
          want_q    = {want_q, b};
        end
      end
    end else if (who < N && pend[who]) begin
      pend[who] = 1'b0;
      up[who]   = 1'b1;
      lat[who]  = round_ms;
      if (pend_cnt > 0) pend_cnt--;
      if (pend_cnt == 0) begin
        round_on = 1'b0;
        queue_report();
      end
    end
  endfunction

  // offer one input beat, with random gaps ahead of it
  task automatic send_beat(input logic m, input logic [TGT_W-1:0] who);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    responder <= who;
    do @(posedge clk); while (!in_ready);
    predict_beat(m, who);
  endtask

  // stop sending and wait for every expected beat, then let the block settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (want_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (want_q.size() != 0) begin
      $error("%0d expected beats never arrived", want_q.size());
      errors++;
      want_q.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_POLL_INTERVAL) poll_ms = val;
    else if (idx == REG_RESP_TIMEOUT) timeout_ms = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // a random beat; while a round runs, answers mostly come from pending targets
  task automatic random_beat();
    int live[$];
    logic [TGT_W-1:0] who;
    who = TGT_W'($urandom_range(15));
    if (round_on && $urandom_range(99) < 45) begin
      for (int i = 0; i < N; i++) if (pend[i]) live = {live, i};
      if (live.size() != 0 && $urandom_range(99) < 75)
        who = TGT_W'(live[$urandom_range(live.size() - 1)]);
      send_beat(MODE_RESP, who);
    end else if (!round_on && $urandom_range(99) < 10) begin
      send_beat(MODE_RESP, who);
    end else begin
      send_beat(MODE_TICK, who);
    end
  endtask

  // first tick after reset starts a round; stray and repeated answers ignored
  task automatic test_first_round();
    send_beat(MODE_TICK, 4'hF);
    send_beat(MODE_RESP, 4'hF);
    send_beat(MODE_TICK, 4'h0);
    send_beat(MODE_RESP, 4'd0);
    send_beat(MODE_RESP, 4'd0);
    send_beat(MODE_TICK, 4'hA);
    send_beat(MODE_RESP, 4'd1);
    send_beat(MODE_RESP, 4'd2);
    send_beat(MODE_TICK, 4'h5);
    send_beat(MODE_RESP, 4'd3);
    send_beat(MODE_RESP, 4'd4);
    send_beat(MODE_TICK, 4'h0);
    send_beat(MODE_RESP, 4'd2);
    wait_idle();
  endtask

  // ticks well short of the reset poll interval start nothing
  task automatic test_default_timing();
    repeat (20) send_beat(MODE_TICK, 4'h0);
    send_beat(MODE_RESP, 4'd2);
    wait_idle();
  endtask

  // zero interval restarts on every idle tick, zero timeout ends on the next tick
  task automatic test_zero_settings();
    write_reg(REG_POLL_INTERVAL, 16'h0000);
    write_reg(REG_RESP_TIMEOUT, 16'h0000);
    repeat (5) send_beat(MODE_TICK, 4'h3);
    send_beat(MODE_RESP, 4'd3);
    send_beat(MODE_TICK, 4'h3);
    wait_idle();
  endtask

  // writes to unmapped indexes leave the settings alone
  task automatic test_register_map();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hA5A5);
    send_beat(MODE_TICK, 4'h0);
    send_beat(MODE_TICK, 4'h0);
    wait_idle();
    write_reg(REG_POLL_INTERVAL, 16'd3);
    write_reg(REG_RESP_TIMEOUT, 16'd2);
    write_reg(REG_SPARE_HI, 16'h0001);
    repeat (4) send_beat(MODE_TICK, 4'h0);
    send_beat(MODE_RESP, 4'd1);
    repeat (4) send_beat(MODE_TICK, 4'h0);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps going, so the input stalls
  task automatic test_backpressure();
    write_reg(REG_POLL_INTERVAL, 16'd2);
    write_reg(REG_RESP_TIMEOUT, 16'd4);
    stall_left = 300;
    repeat (40) random_beat();
    wait_idle();
  endtask

  task automatic test_random(input int count, input int snd, input int rcv);
    send_idle = snd;
    recv_idle = rcv;
    for (int c = 0; c < 2; c++) begin
      wait_idle();
      write_reg(REG_POLL_INTERVAL, 16'($urandom_range(12)));
      write_reg(REG_RESP_TIMEOUT, 16'($urandom_range(15)));
      repeat (count / 2) random_beat();
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 8;
    recv_idle = 70;
    test_first_round();
    test_default_timing();
    test_zero_settings();
    test_register_map();
    test_backpressure();
    test_random(80, 8, 70);
    test_random(80, 70, 8);
    test_random(80, 0, 0);
    wait_idle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
